// ----- rtl/core/kht_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath command types for the key hold table.
// No dependencies; all other files but kht_ram use this package, by scoped names or by import.

package kht_pkg;

   // Table sizes
   localparam int TIMEOUT_ENTRIES = 16;
   localparam int KEY_COUNT       = 64;
   localparam int PORT_COUNT      = 4;

   // Field widths of an item
   localparam int ACT_W  = 2;
   localparam int KEY_W  = 6;
   localparam int PORT_W = 2;
   localparam int SRC_W  = 5;
   localparam int HOLD_W = 16;
   localparam int TIME_W = 32;

   // Derived index and count widths
   localparam int ENTRY_IDX_W = (TIMEOUT_ENTRIES > 1) ? $clog2(TIMEOUT_ENTRIES) : 1;
   localparam int ENTRY_CNT_W = $clog2(TIMEOUT_ENTRIES + 1);
   localparam int HELD_ADDR_W = $clog2(KEY_COUNT);

   // Source code used for injected releases on a port reset
   localparam logic signed [SRC_W-1:0] SRC_INJECTED = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_PRESS      = 2'd0,
      ACT_RELEASE    = 2'd1,
      ACT_TICK       = 2'd2,
      ACT_PORT_RESET = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PRESS_UPD,
      ST_RELEASE_UPD,
      ST_HELD_RD,
      ST_HELD_WR,
      ST_SCAN,
      ST_DROP,
      ST_KEY_RD,
      ST_KEY_CHK,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_PRESS,
      TBL_RELEASE,
      TBL_DROP
   } tbl_op_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;       // take the input item
      tbl_op_type tbl_op;        // timeout table update
      logic       idx_load;      // scan index <= entry count
      logic       scan_check;    // test the entry below the scan index
      logic       key_clear;     // key scan pointer <= 0
      logic       key_next;      // key scan pointer + 1
      logic       held_sel_scan; // held memory addressed by the key scan pointer
      logic       held_write;    // write back the held bits
      logic       evt_load;      // new event into the pending slot
      logic       evt_sel_scan;  // event comes from the key scan
      logic       flush;         // push the pending event as the final one
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type action;
      logic       port_ok;
      logic       idx_zero;
      logic       scan_hit;
      logic       key_last;
      logic       key_bit;
      logic       evt_stall;
   } status_type;

endpackage

// ----- rtl/core/kht_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response items.
// Depends on kht_pkg for field widths.

interface kht_req_if;
   logic                                valid;
   logic                                ready;
   logic [kht_pkg::ACT_W-1:0]           action;
   logic [kht_pkg::KEY_W-1:0]           key_id;
   logic [kht_pkg::PORT_W-1:0]          port;
   logic signed [kht_pkg::SRC_W-1:0]    source_id;
   logic [kht_pkg::HOLD_W-1:0]          hold_ms;
   logic [kht_pkg::TIME_W-1:0]          now_time;

   modport source (output valid, action, key_id, port, source_id, hold_ms, now_time,
                   input ready);
   modport sink   (input valid, action, key_id, port, source_id, hold_ms, now_time,
                   output ready);
endinterface

interface kht_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [kht_pkg::KEY_W-1:0]           event_key;
   logic                                event_pressed;
   logic [kht_pkg::PORT_W-1:0]          event_port;
   logic signed [kht_pkg::SRC_W-1:0]    event_source;
   logic                                last;

   modport source (output valid, event_key, event_pressed, event_port, event_source, last,
                   input ready);
   modport sink   (input valid, event_key, event_pressed, event_port, event_source, last,
                   output ready);
endinterface

// ----- rtl/core/kht_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module kht_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/kht_controller.sv -----
`timescale 1ns / 1ps
// Sequencer of the key hold table: decodes an item and steps the datapath.
// Depends on kht_pkg for the state, command and status types.

module kht_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kht_pkg::status_type status,
   output kht_pkg::cmd_type    cmd
);

   kht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kht_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kht_pkg::ST_IDLE: begin
            if (req_valid) state_in = kht_pkg::ST_DECODE;
         end
         kht_pkg::ST_DECODE: begin
            case (status.action)
               kht_pkg::ACT_PRESS:   state_in = kht_pkg::ST_PRESS_UPD;
               kht_pkg::ACT_RELEASE: state_in = kht_pkg::ST_RELEASE_UPD;
               kht_pkg::ACT_TICK:    state_in = kht_pkg::ST_SCAN;
               default: begin
                  state_in = status.port_ok ? kht_pkg::ST_KEY_RD : kht_pkg::ST_IDLE;
               end
            endcase
         end
         kht_pkg::ST_PRESS_UPD:   state_in = kht_pkg::ST_HELD_RD;
         kht_pkg::ST_RELEASE_UPD: state_in = kht_pkg::ST_HELD_RD;
         kht_pkg::ST_HELD_RD:     state_in = kht_pkg::ST_HELD_WR;
         kht_pkg::ST_HELD_WR: begin
            if (!status.evt_stall) begin
               state_in = (status.action == kht_pkg::ACT_TICK) ? kht_pkg::ST_SCAN
                                                                : kht_pkg::ST_FLUSH;
            end
         end
         kht_pkg::ST_SCAN: begin
            if (status.idx_zero) state_in = kht_pkg::ST_FLUSH;
            else if (status.scan_hit) state_in = kht_pkg::ST_DROP;
         end
         kht_pkg::ST_DROP: begin
            state_in = (status.action == kht_pkg::ACT_TICK) ? kht_pkg::ST_HELD_RD
                                                             : kht_pkg::ST_SCAN;
         end
         kht_pkg::ST_KEY_RD: state_in = kht_pkg::ST_KEY_CHK;
         kht_pkg::ST_KEY_CHK: begin
            if (!(status.key_bit && status.evt_stall)) begin
               state_in = status.key_last ? kht_pkg::ST_SCAN : kht_pkg::ST_KEY_RD;
            end
         end
         kht_pkg::ST_FLUSH: begin
            if (!status.evt_stall) state_in = kht_pkg::ST_IDLE;
         end
         default: state_in = kht_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.tbl_op = kht_pkg::TBL_NONE;
      case (state_ff)
         kht_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         kht_pkg::ST_DECODE: begin
            cmd.idx_load  = (status.action == kht_pkg::ACT_TICK);
            cmd.key_clear = (status.action == kht_pkg::ACT_PORT_RESET);
         end
         kht_pkg::ST_PRESS_UPD:   cmd.tbl_op = kht_pkg::TBL_PRESS;
         kht_pkg::ST_RELEASE_UPD: cmd.tbl_op = kht_pkg::TBL_RELEASE;
         kht_pkg::ST_HELD_RD: begin
         end
         kht_pkg::ST_HELD_WR: begin
            if (!status.evt_stall) begin
               cmd.held_write = 1'b1;
               cmd.evt_load   = 1'b1;
            end
         end
         kht_pkg::ST_SCAN: begin
            cmd.scan_check = !status.idx_zero;
         end
         kht_pkg::ST_DROP: cmd.tbl_op = kht_pkg::TBL_DROP;
         kht_pkg::ST_KEY_RD: cmd.held_sel_scan = 1'b1;
         kht_pkg::ST_KEY_CHK: begin
            cmd.held_sel_scan = 1'b1;
            if (!(status.key_bit && status.evt_stall)) begin
               cmd.held_write   = status.key_bit;
               cmd.evt_load     = status.key_bit;
               cmd.evt_sel_scan = 1'b1;
               cmd.key_next     = !status.key_last;
               cmd.idx_load     = status.key_last;
            end
         end
         kht_pkg::ST_FLUSH: begin
            cmd.flush = !status.evt_stall;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/kht_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the key hold table: timeout entries, held-bit memory, event slots.
// Depends on kht_pkg and kht_ram.

module kht_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  kht_pkg::cmd_type                    cmd,
   output kht_pkg::status_type                 status,
   input  logic [kht_pkg::ACT_W-1:0]           req_action,
   input  logic [kht_pkg::KEY_W-1:0]           req_key_id,
   input  logic [kht_pkg::PORT_W-1:0]          req_port,
   input  logic signed [kht_pkg::SRC_W-1:0]    req_source,
   input  logic [kht_pkg::HOLD_W-1:0]          req_hold_ms,
   input  logic [kht_pkg::TIME_W-1:0]          req_now_time,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [kht_pkg::KEY_W-1:0]           rsp_event_key,
   output logic                                rsp_event_pressed,
   output logic [kht_pkg::PORT_W-1:0]          rsp_event_port,
   output logic signed [kht_pkg::SRC_W-1:0]    rsp_event_source,
   output logic                                rsp_last
);

   localparam int N   = kht_pkg::TIMEOUT_ENTRIES;
   localparam int EIW = kht_pkg::ENTRY_IDX_W;
   localparam int ECW = kht_pkg::ENTRY_CNT_W;
   localparam int HAW = kht_pkg::HELD_ADDR_W;
   localparam int KW  = kht_pkg::KEY_W;
   localparam int PW  = kht_pkg::PORT_W;
   localparam int SW  = kht_pkg::SRC_W;
   localparam int TW  = kht_pkg::TIME_W;
   localparam int PC  = kht_pkg::PORT_COUNT;

   // Item registers
   kht_pkg::action_type    action_ff, action_in;
   logic [PW-1:0]          port_ff, port_in;
   logic [kht_pkg::HOLD_W-1:0] hold_ff, hold_in;
   logic [TW-1:0]          now_ff, now_in;
   logic [KW-1:0]          hit_key_ff, hit_key_in;
   logic [PW-1:0]          hit_port_ff, hit_port_in;
   logic signed [SW-1:0]   hit_src_ff, hit_src_in;

   // Scan and count registers
   logic [ECW-1:0]         count_ff, count_in;
   logic [ECW-1:0]         idx_ff, idx_in;
   logic [HAW-1:0]         key_ptr_ff, key_ptr_in;

   // Timeout entries
   logic [KW-1:0]          ent_key_ff  [N];
   logic [PW-1:0]          ent_port_ff [N];
   logic signed [SW-1:0]   ent_src_ff  [N];
   logic [TW-1:0]          ent_exp_ff  [N];
   logic [KW-1:0]          ent_key_in;
   logic [PW-1:0]          ent_port_in;
   logic signed [SW-1:0]   ent_src_in;
   logic [TW-1:0]          ent_exp_in;
   logic                   tbl_we;
   logic [EIW-1:0]         tbl_waddr;

   // Held bits
   logic [kht_pkg::KEY_COUNT-1:0] held_valid_ff, held_valid_in;
   logic                   held_we;
   logic [HAW-1:0]         held_waddr, held_raddr;
   logic [PC-1:0]          held_wdata, held_q, held_eff;
   logic [PC-1:0]          hit_mask, scan_mask;
   logic                   hit_ok;

   // Pending and output events
   logic                   pend_valid_ff, pend_valid_in;
   logic [KW-1:0]          pend_key_ff, pend_key_in;
   logic                   pend_pressed_ff, pend_pressed_in;
   logic [PW-1:0]          pend_port_ff, pend_port_in;
   logic signed [SW-1:0]   pend_src_ff, pend_src_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]          rsp_key_ff, rsp_key_in;
   logic                   rsp_pressed_ff, rsp_pressed_in;
   logic [PW-1:0]          rsp_port_ff, rsp_port_in;
   logic signed [SW-1:0]   rsp_src_ff, rsp_src_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   push, evt_stall;

   // Combinational helpers
   logic [ECW-1:0]         cnt_m1, idx_m1;
   logic [EIW-1:0]         last_addr, scan_addr, rd_addr;
   logic [KW-1:0]          rd_key;
   logic [PW-1:0]          rd_port;
   logic signed [SW-1:0]   rd_src;
   logic [TW-1:0]          rd_exp;
   logic                   match_found;
   logic [EIW-1:0]         match_idx;
   logic [TW:0]            exp_sum;
   logic [TW-1:0]          expiry;
   logic                   scan_hit;

   // Table read port: the last entry for a swap, else the entry under the scan
   assign cnt_m1    = count_ff - ECW'(1);
   assign idx_m1    = idx_ff - ECW'(1);
   assign last_addr = cnt_m1[EIW-1:0];
   assign scan_addr = idx_m1[EIW-1:0];
   assign rd_addr   = (cmd.tbl_op == kht_pkg::TBL_RELEASE || cmd.tbl_op == kht_pkg::TBL_DROP)
                      ? last_addr : scan_addr;
   assign rd_key    = ent_key_ff[rd_addr];
   assign rd_port   = ent_port_ff[rd_addr];
   assign rd_src    = ent_src_ff[rd_addr];
   assign rd_exp    = ent_exp_ff[rd_addr];

   // First live entry matching key, port and source
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = 0; i < N; i++) begin
         if (!match_found && (ECW'(i) < count_ff) && ent_key_ff[i] == hit_key_ff &&
             ent_port_ff[i] == hit_port_ff && ent_src_ff[i] == hit_src_ff) begin
            match_found = 1'b1;
            match_idx   = EIW'(i);
         end
      end
   end

   // Saturating expiry
   assign exp_sum = {1'b0, now_ff} + (TW+1)'(hold_ff);
   assign expiry  = exp_sum[TW] ? '1 : exp_sum[TW-1:0];

   // Scan test: expired on a tick, same port on a port reset
   assign scan_hit = (action_ff == kht_pkg::ACT_TICK) ? (now_ff >= rd_exp)
                                                       : (rd_port == port_ff);

   // Item capture and scan hit capture
   always_comb begin
      action_in   = action_ff;
      port_in     = port_ff;
      hold_in     = hold_ff;
      now_in      = now_ff;
      hit_key_in  = hit_key_ff;
      hit_port_in = hit_port_ff;
      hit_src_in  = hit_src_ff;
      if (cmd.capture) begin
         action_in   = kht_pkg::action_type'(req_action);
         port_in     = req_port;
         hold_in     = req_hold_ms;
         now_in      = req_now_time;
         hit_key_in  = req_key_id;
         hit_port_in = req_port;
         hit_src_in  = req_source;
      end else if (cmd.scan_check && scan_hit) begin
         hit_key_in  = rd_key;
         hit_port_in = rd_port;
         hit_src_in  = rd_src;
      end
   end

   // Table update, count and scan index
   always_comb begin
      tbl_we      = 1'b0;
      tbl_waddr   = match_idx;
      ent_key_in  = hit_key_ff;
      ent_port_in = hit_port_ff;
      ent_src_in  = hit_src_ff;
      ent_exp_in  = expiry;
      count_in    = count_ff;
      idx_in      = idx_ff;
      case (cmd.tbl_op)
         kht_pkg::TBL_PRESS: begin
            if (hold_ff != '0) begin
               if (match_found) begin
                  tbl_we = 1'b1;
               end else if (count_ff < ECW'(N)) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = count_ff[EIW-1:0];
                  count_in  = count_ff + ECW'(1);
               end
            end
         end
         kht_pkg::TBL_RELEASE: begin
            if (match_found) begin
               tbl_we      = 1'b1;
               ent_key_in  = rd_key;
               ent_port_in = rd_port;
               ent_src_in  = rd_src;
               ent_exp_in  = rd_exp;
               count_in    = cnt_m1;
            end
         end
         kht_pkg::TBL_DROP: begin
            tbl_we      = 1'b1;
            tbl_waddr   = scan_addr;
            ent_key_in  = rd_key;
            ent_port_in = rd_port;
            ent_src_in  = rd_src;
            ent_exp_in  = rd_exp;
            count_in    = cnt_m1;
            idx_in      = idx_m1;
         end
         default: begin
         end
      endcase
      if (cmd.idx_load) begin
         idx_in = count_ff;
      end else if (cmd.scan_check && !scan_hit) begin
         idx_in = idx_m1;
      end
   end

   // Key scan pointer
   always_comb begin
      key_ptr_in = key_ptr_ff;
      if (cmd.key_clear) key_ptr_in = '0;
      else if (cmd.key_next) key_ptr_in = key_ptr_ff + HAW'(1);
   end

   // Held bits: unwritten words read as zero
   assign held_raddr = cmd.held_sel_scan ? key_ptr_ff : hit_key_ff[HAW-1:0];
   assign held_eff   = held_valid_ff[held_raddr] ? held_q : '0;
   assign hit_mask   = PC'(1) << hit_port_ff;
   assign scan_mask  = PC'(1) << port_ff;
   assign hit_ok     = ({1'b0, hit_key_ff} < (KW+1)'(kht_pkg::KEY_COUNT)) &&
                       ({1'b0, hit_port_ff} < (PW+1)'(PC));

   always_comb begin
      held_we    = 1'b0;
      held_waddr = hit_key_ff[HAW-1:0];
      held_wdata = held_eff & ~hit_mask;
      if (cmd.held_write) begin
         if (cmd.held_sel_scan) begin
            held_we    = 1'b1;
            held_waddr = key_ptr_ff;
            held_wdata = held_eff & ~scan_mask;
         end else begin
            held_we = hit_ok;
            if (action_ff == kht_pkg::ACT_PRESS) held_wdata = held_eff | hit_mask;
         end
      end
      held_valid_in = held_valid_ff;
      if (held_we) held_valid_in[held_waddr] = 1'b1;
   end

   kht_ram #(
      .WIDTH (PC),
      .DEPTH (kht_pkg::KEY_COUNT)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (held_we),
      .wr_addr (held_waddr),
      .wr_data (held_wdata),
      .rd_addr (held_raddr),
      .rd_data (held_q)
   );

   // Event slots: one pending item, one output item
   assign evt_stall = pend_valid_ff && rsp_valid_ff && !rsp_ready;
   assign push      = (cmd.evt_load || cmd.flush) && pend_valid_ff;

   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_key_in     = pend_key_ff;
      pend_pressed_in = pend_pressed_ff;
      pend_port_in    = pend_port_ff;
      pend_src_in     = pend_src_ff;
      if (cmd.evt_load) begin
         pend_valid_in = 1'b1;
         if (cmd.evt_sel_scan) begin
            pend_key_in     = KW'(key_ptr_ff);
            pend_pressed_in = 1'b0;
            pend_port_in    = port_ff;
            pend_src_in     = kht_pkg::SRC_INJECTED;
         end else begin
            pend_key_in     = hit_key_ff;
            pend_pressed_in = (action_ff == kht_pkg::ACT_PRESS);
            pend_port_in    = hit_port_ff;
            pend_src_in     = hit_src_ff;
         end
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_key_in     = rsp_key_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_last_in    = rsp_last_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_key_in     = pend_key_ff;
         rsp_pressed_in = pend_pressed_ff;
         rsp_port_in    = pend_port_ff;
         rsp_src_in     = pend_src_ff;
         rsp_last_in    = cmd.flush;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         held_valid_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      port_ff         <= port_in;
      hold_ff         <= hold_in;
      now_ff          <= now_in;
      hit_key_ff      <= hit_key_in;
      hit_port_ff     <= hit_port_in;
      hit_src_ff      <= hit_src_in;
      idx_ff          <= idx_in;
      key_ptr_ff      <= key_ptr_in;
      pend_key_ff     <= pend_key_in;
      pend_pressed_ff <= pend_pressed_in;
      pend_port_ff    <= pend_port_in;
      pend_src_ff     <= pend_src_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_pressed_ff  <= rsp_pressed_in;
      rsp_port_ff     <= rsp_port_in;
      rsp_src_ff      <= rsp_src_in;
      rsp_last_ff     <= rsp_last_in;
      if (tbl_we) begin
         ent_key_ff[tbl_waddr]  <= ent_key_in;
         ent_port_ff[tbl_waddr] <= ent_port_in;
         ent_src_ff[tbl_waddr]  <= ent_src_in;
         ent_exp_ff[tbl_waddr]  <= ent_exp_in;
      end
   end

   // Status
   assign status.action    = action_ff;
   assign status.port_ok   = ({1'b0, port_ff} < (PW+1)'(PC));
   assign status.idx_zero  = (idx_ff == '0);
   assign status.scan_hit  = scan_hit;
   assign status.key_last  = (key_ptr_ff == HAW'(kht_pkg::KEY_COUNT - 1));
   assign status.key_bit   = |(held_eff & scan_mask);
   assign status.evt_stall = evt_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_key     = rsp_key_ff;
   assign rsp_event_pressed = rsp_pressed_ff;
   assign rsp_event_port    = rsp_port_ff;
   assign rsp_event_source  = rsp_src_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- rtl/core/key_hold_timeout_table.sv -----
`timescale 1ns / 1ps
// Press and release: decode, table update, held-bit read and write, then the event is
// flushed into the output register; the next item is accepted after the flush.
// Tick: live timeout entries are scanned from the last down; expired ones are dropped.
// Port reset: held-bit memory read for every key, written where the port's bit is set,
// then the entries on the port dropped; the output register stalls it.
// Synchronous reset empties the timeout table and clears all held bits at once.

module key_hold_timeout_table (
   input  logic      clock,
   input  logic      reset,
   kht_req_if.sink   req_ch,
   kht_rsp_if.source rsp_ch
);

   kht_pkg::cmd_type    cmd;
   kht_pkg::status_type status;

   // Sequencer
   kht_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables and event slots
   kht_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_ch.action),
      .req_key_id        (req_ch.key_id),
      .req_port          (req_ch.port),
      .req_source        (req_ch.source_id),
      .req_hold_ms       (req_ch.hold_ms),
      .req_now_time      (req_ch.now_time),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_event_key     (rsp_ch.event_key),
      .rsp_event_pressed (rsp_ch.event_pressed),
      .rsp_event_port    (rsp_ch.event_port),
      .rsp_event_source  (rsp_ch.event_source),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// ----- rtl/core/kht_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the key hold table, bound to the top level.
// Depends on kht_pkg and on key_hold_timeout_table.

module kht_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [kht_pkg::KEY_W-1:0]           rsp_event_key,
   input logic                                rsp_event_pressed,
   input logic [kht_pkg::PORT_W-1:0]          rsp_event_port,
   input logic signed [kht_pkg::SRC_W-1:0]    rsp_event_source,
   input logic                                rsp_last
);

   // Stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   // Stalled item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_event_key) && $stable(rsp_event_pressed) &&
      $stable(rsp_event_port) && $stable(rsp_event_source) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // One item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // A press produces exactly one event
   a_press_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_pressed |-> rsp_last)
      else $error("press event not marked last");

   // Out of reset: idle, nothing offered
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind key_hold_timeout_table kht_port_checks u_kht_port_checks (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_event_key     (rsp_ch.event_key),
   .rsp_event_pressed (rsp_ch.event_pressed),
   .rsp_event_port    (rsp_ch.event_port),
   .rsp_event_source  (rsp_ch.event_source),
   .rsp_last          (rsp_ch.last)
);

// ----- bench/kht_checker.sv -----
`timescale 1ns / 1ps
// Event checker for key_hold_timeout_table: keeps its own copy of the hold table and held bits,
// predicts the events of each accepted item and compares them with the response channel.
// Depends on kht_pkg and on the kht_req_if / kht_rsp_if interfaces.

module kht_checker (
   input  logic clock,
   input  logic reset,
   kht_req_if   req_ch,
   kht_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   events_checked,
   output int   events_pending
);
   import kht_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0]        key;
      logic                    pressed;
      logic [PORT_W-1:0]       port;
      logic signed [SRC_W-1:0] source;
      logic                    last;
   } key_event_type;

   // Shadow of the timed holds and of the per-port held bits
   logic [KEY_W-1:0]      hold_key    [TIMEOUT_ENTRIES];
   logic [PORT_W-1:0]     hold_port   [TIMEOUT_ENTRIES];
   logic [SRC_W-1:0]      hold_source [TIMEOUT_ENTRIES];
   logic [TIME_W-1:0]     hold_expiry [TIMEOUT_ENTRIES];
   int                    hold_count;
   logic [PORT_COUNT-1:0] held_ports  [KEY_COUNT];

   key_event_type expected_events [$];
   key_event_type want;

   initial begin
      mismatch_count = 0;
      events_checked = 0;
      events_pending = 0;
      hold_count     = 0;
   end

   function automatic key_event_type make_event(input logic [KEY_W-1:0] key,
                                                input logic pressed,
                                                input logic [PORT_W-1:0] port,
                                                input logic [SRC_W-1:0] src);
      key_event_type ev;
      ev.key     = key;
      ev.pressed = pressed;
      ev.port    = port;
      ev.source  = src;
      ev.last    = 1'b0;
      return ev;
   endfunction

   function automatic void set_held(input logic [KEY_W-1:0] key, input logic [PORT_W-1:0] port,
                                    input logic on);
      if (int'(key) < KEY_COUNT && int'(port) < PORT_COUNT)
         held_ports[key][port] = on;
   endfunction

   function automatic int find_hold(input logic [KEY_W-1:0] key, input logic [PORT_W-1:0] port,
                                    input logic [SRC_W-1:0] src);
      for (int i = 0; i < hold_count; i++)
         if (hold_key[i] == key && hold_port[i] == port && hold_source[i] == src)
            return i;
      return -1;
   endfunction

   // Swap-remove: the last hold takes the freed slot
   function automatic void drop_hold(input int idx);
      int tail;
      tail             = hold_count - 1;
      hold_key[idx]    = hold_key[tail];
      hold_port[idx]   = hold_port[tail];
      hold_source[idx] = hold_source[tail];
      hold_expiry[idx] = hold_expiry[tail];
      hold_count       = tail;
   endfunction

   function automatic void predict_events(input action_type act, input logic [KEY_W-1:0] key,
                                          input logic [PORT_W-1:0] port,
                                          input logic [SRC_W-1:0] src,
                                          input logic [HOLD_W-1:0] hold,
                                          input logic [TIME_W-1:0] now);
      key_event_type     batch [$];
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] expiry;
      logic [KEY_W-1:0]  k;
      logic [PORT_W-1:0] p;
      logic [SRC_W-1:0]  s;
      int                slot;
      case (act)
         ACT_PRESS: begin
            // nonzero timeout: refresh a matching hold or append, dropped when full
            if (hold != '0) begin
               sum    = {1'b0, now} + (TIME_W+1)'(hold);
               expiry = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               slot   = find_hold(key, port, src);
               if (slot >= 0) begin
                  hold_expiry[slot] = expiry;
               end else if (hold_count < TIMEOUT_ENTRIES) begin
                  hold_key[hold_count]    = key;
                  hold_port[hold_count]   = port;
                  hold_source[hold_count] = src;
                  hold_expiry[hold_count] = expiry;
                  hold_count++;
               end
            end
            set_held(key, port, 1'b1);
            batch.push_back(make_event(key, 1'b1, port, src));
         end
         ACT_RELEASE: begin
            slot = find_hold(key, port, src);
            if (slot >= 0)
               drop_hold(slot);
            set_held(key, port, 1'b0);
            batch.push_back(make_event(key, 1'b0, port, src));
         end
         ACT_TICK: begin
            // last to first, each expired hold released with its own source
            for (int i = hold_count - 1; i >= 0; i--) begin
               if (now >= hold_expiry[i]) begin
                  k = hold_key[i];
                  p = hold_port[i];
                  s = hold_source[i];
                  drop_hold(i);
                  set_held(k, p, 1'b0);
                  batch.push_back(make_event(k, 1'b0, p, s));
               end
            end
         end
         ACT_PORT_RESET: begin
            if (int'(port) < PORT_COUNT) begin
               for (int i = 0; i < KEY_COUNT; i++) begin
                  if (held_ports[i][port]) begin
                     held_ports[i][port] = 1'b0;
                     batch.push_back(make_event(KEY_W'(i), 1'b0, port, SRC_INJECTED));
                  end
               end
               for (int i = hold_count - 1; i >= 0; i--)
                  if (hold_port[i] == port)
                     drop_hold(i);
            end
         end
         default: begin
         end
      endcase
      if (batch.size() != 0)
         batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
         expected_events.push_back(batch[i]);
   endfunction

   function automatic void compare_field(input string name, input logic signed [31:0] want_v,
                                         input logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // Items are predicted before events are checked, so a same-edge pair stays ordered
   always @(posedge clock) begin
      if (reset) begin
         hold_count = 0;
         foreach (held_ports[i])
            held_ports[i] = '0;
         expected_events.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_events(action_type'(req_ch.action), req_ch.key_id, req_ch.port,
                           req_ch.source_id, req_ch.hold_ms, req_ch.now_time);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events.size() == 0) begin
               $error("event with nothing expected: key %0d port %0d pressed %0b",
                      rsp_ch.event_key, rsp_ch.event_port, rsp_ch.event_pressed);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               compare_field("event_key", want.key, rsp_ch.event_key);
               compare_field("event_pressed", want.pressed, rsp_ch.event_pressed);
               compare_field("event_port", want.port, rsp_ch.event_port);
               compare_field("event_source", want.source, rsp_ch.event_source);
               compare_field("last", want.last, rsp_ch.last);
               events_checked++;
            end
         end
      end
      events_pending = expected_events.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for key_hold_timeout_table: clock, reset, item stimulus, receiver stalls, verdict.
// Depends on kht_pkg, the kht_if interfaces and kht_checker, which predicts and compares events.

module tb_top;
   import kht_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 9;
   localparam int RANDOM_ITEMS     = 305;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int TAIL_CYCLES      = 250;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PORT_W-1:0] port;
      logic [SRC_W-1:0]  source;
   } pressed_key_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          mismatch_count;
   int          events_checked;
   int          events_pending;
   int          quiet_cycles = 0;
   int          sent_by_action [4] = '{0, 0, 0, 0};
   logic        hold_off_req  = 1'b0;
   logic        hold_off_done = 1'b0;
   rx_mode_type rx_mode;
   int          rx_len;
   int          rx_phase = 0;

   kht_req_if req_ch ();
   kht_rsp_if rsp_ch ();

   key_hold_timeout_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   kht_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .events_checked (events_checked),
      .events_pending (events_pending)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d events outstanding",
                  quiet_cycles, events_pending);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stall segments of random mode, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         rx_len  = $urandom_range(200, 20);
         rx_mode = rx_mode_type'($urandom_range(3, 0));
         repeat (rx_len) begin
            @(negedge clock);
            if (hold_off_req && !hold_off_done) begin
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
               hold_off_done = 1'b1;
            end
            case (rx_mode)
               RX_OPEN:  rsp_ch.ready <= 1'b1;
               RX_LIGHT: rsp_ch.ready <= ($urandom_range(3, 0) != 0);
               RX_HEAVY: rsp_ch.ready <= ($urandom_range(3, 0) == 0);
               default:  rsp_ch.ready <= (rx_phase % 3 != 0);
            endcase
            rx_phase++;
         end
      end
   end

   function automatic logic [SRC_W-1:0] random_source();
      int pick;
      pick = $urandom_range(16, 0);
      return (pick == 16) ? SRC_INJECTED : SRC_W'(pick);
   endfunction

   // Mostly a small pool of keys at both ends, so presses and releases meet
   function automatic logic [KEY_W-1:0] random_key();
      int pick;
      if ($urandom_range(9, 0) < 7) begin
         pick = $urandom_range(11, 0);
         return (pick < 6) ? KEY_W'(pick) : KEY_W'(52 + pick);
      end
      return KEY_W'($urandom_range(KEY_COUNT - 1, 0));
   endfunction

   // Drop valid for a number of cycles, with noise on the payload
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid     <= 1'b0;
         req_ch.action    <= ACT_W'($urandom_range(3, 0));
         req_ch.key_id    <= KEY_W'($urandom);
         req_ch.port      <= PORT_W'($urandom);
         req_ch.source_id <= SRC_W'($urandom);
         req_ch.hold_ms   <= HOLD_W'($urandom);
         req_ch.now_time  <= $urandom;
      end
   endtask

   task automatic send_item(input action_type act, input logic [KEY_W-1:0] key,
                            input logic [PORT_W-1:0] port, input logic [SRC_W-1:0] src,
                            input logic [HOLD_W-1:0] hold, input logic [TIME_W-1:0] now);
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.key_id    <= key;
      req_ch.port      <= port;
      req_ch.source_id <= src;
      req_ch.hold_ms   <= hold;
      req_ch.now_time  <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_by_action[int'(act)]++;
   endtask

   task automatic wait_for_drain();
      idle_for(1);
      while (events_pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      pressed_key_type   recent [$];
      pressed_key_type   pick;
      action_type        act;
      logic [KEY_W-1:0]  key;
      logic [PORT_W-1:0] port;
      logic [SRC_W-1:0]  src;
      logic [HOLD_W-1:0] hold;
      logic [TIME_W-1:0] wall_ms;
      int                roll;
      int                idx;
      int                burst_left;

      req_ch.valid     = 1'b0;
      req_ch.action    = '0;
      req_ch.key_id    = '0;
      req_ch.port      = '0;
      req_ch.source_id = '0;
      req_ch.hold_ms   = '0;
      req_ch.now_time  = '0;
      wall_ms          = '0;
      burst_left       = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, no timeout, saturation, refresh, full table,
      // release with a different source, expiry exactly at now, port resets
      send_item(ACT_TICK, '0, '0, '0, '0, '0);
      send_item(ACT_PORT_RESET, '0, 2'd2, '0, '0, '0);
      send_item(ACT_PRESS, '0, '0, SRC_INJECTED, '0, '0);
      send_item(ACT_PRESS, '1, 2'd3, 5'd15, '1, 32'hFFFF_FFF0);
      send_item(ACT_PRESS, '1, 2'd3, 5'd15, 16'd10, 32'd100);
      for (int i = 1; i < TIMEOUT_ENTRIES; i++) begin
         send_item(ACT_PRESS, KEY_W'(i), PORT_W'(i % 4), SRC_W'(i), 16'd50, 32'd100);
         idle_for($urandom_range(2, 0));
      end
      send_item(ACT_PRESS, KEY_W'(40), 2'd1, 5'd3, 16'd20, 32'd100);
      send_item(ACT_RELEASE, '1, 2'd3, 5'd15, '0, 32'd120);
      send_item(ACT_RELEASE, KEY_W'(5), 2'd1, 5'd4, '0, 32'd120);
      send_item(ACT_TICK, '0, '0, '0, '0, 32'd149);
      send_item(ACT_TICK, '0, '0, '0, '0, 32'd150);
      send_item(ACT_PORT_RESET, '0, 2'd1, '0, '0, '0);
      send_item(ACT_PORT_RESET, '0, 2'd0, '0, '0, '1);
      wait_for_drain();

      // Random: press/release pairs over advancing time, ticks and port resets
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 40)
            hold_off_req = 1'b1;
         if (n == 150)
            wait_for_drain();
         if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            if (n < 200 || n >= 240)
               idle_for($urandom_range(12, 0));
         end
         burst_left--;

         roll = $urandom_range(99, 0);
         if (roll < 3)
            wall_ms = $urandom;
         else if (roll < 5)
            wall_ms = 32'hFFFF_FFFF - $urandom_range(300, 0);
         else
            wall_ms = wall_ms + $urandom_range(40, 0);

         key  = random_key();
         port = PORT_W'($urandom_range(3, 0));
         src  = random_source();
         hold = HOLD_W'($urandom);
         roll = $urandom_range(99, 0);
         if (roll < 45) begin
            act  = ACT_PRESS;
            roll = $urandom_range(99, 0);
            if (roll < 10)
               hold = '0;
            else if (roll < 15)
               hold = '1;
            else if (roll < 85)
               hold = HOLD_W'($urandom_range(200, 1));
            recent.push_back('{key, port, src});
            if (recent.size() > 24)
               recent.delete(0);
         end else if (roll < 70) begin
            act = ACT_RELEASE;
            // mostly a key that was pressed, otherwise a stray release
            if (recent.size() != 0 && $urandom_range(9, 0) < 7) begin
               idx  = $urandom_range(recent.size() - 1, 0);
               pick = recent[idx];
               recent.delete(idx);
               key  = pick.key;
               port = pick.port;
               src  = pick.source;
            end
         end else if (roll < 90) begin
            act = ACT_TICK;
         end else begin
            act = ACT_PORT_RESET;
         end
         send_item(act, key, port, src, hold, wall_ms);
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d items: %0d press, %0d release, %0d tick, %0d port reset.",
               sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
               sent_by_action[0], sent_by_action[1], sent_by_action[2], sent_by_action[3]);
      $display("Checked %0d events, %0d mismatches, %0d still expected.",
               events_checked, mismatch_count, events_pending);
      if (mismatch_count == 0 && events_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/kht_pkg.sv
rtl/core/kht_if.sv
rtl/core/kht_ram.sv
rtl/core/kht_controller.sv
rtl/core/kht_datapath.sv
rtl/core/key_hold_timeout_table.sv
rtl/core/kht_checker.sv
bench/kht_checker.sv
bench/tb_top.sv
